### rtl/lpr_pkg.sv
package lpr_pkg;

    typedef enum logic [3:0] {
        CFG_ENABLE          = 4'd0,
        CFG_FB_WIDTH        = 4'd1,
        CFG_FB_HEIGHT       = 4'd2,
        CFG_ROW_PITCH       = 4'd3,
        CFG_BYTES_PER_PIXEL = 4'd4,
        CFG_RED_LAYOUT      = 4'd5,
        CFG_GREEN_LAYOUT    = 4'd6,
        CFG_BLUE_LAYOUT     = 4'd7
    } t_cfg_reg;

    typedef enum logic {
        OP_START   = 1'b0,
        OP_ADVANCE = 1'b1
    } t_op;

    localparam int          CFG_INDEX_W  = 4;
    localparam int          CFG_DATA_W   = 16;
    localparam int          FB_DIM_W     = 14;
    localparam int          PITCH_W      = 16;
    localparam int          BPP_W        = 3;
    localparam int          LAYOUT_W     = 9;
    localparam int          CHAN_W       = 8;
    localparam int          PIXEL_W      = 32;
    localparam logic [2:0]  BPP_3        = 3'd3;
    localparam logic [2:0]  BPP_4        = 3'd4;
    localparam logic [3:0]  CHAN_SIZE_MAX = 4'd8;

    // one colour channel: keep the top size bits, then move them to pos
    function automatic logic [PIXEL_W-1:0] pack_channel(
        input logic [CHAN_W-1:0]   value,
        input logic [LAYOUT_W-1:0] layout
    );
        logic [3:0]        size;
        logic [4:0]        pos;
        logic [CHAN_W-1:0] top;
        size = layout[8:5];
        pos  = layout[4:0];
        if (size > CHAN_SIZE_MAX) begin
            size = CHAN_SIZE_MAX;
        end
        if (size == 4'd0) begin
            top = '0;
        end else begin
            top = value >> (CHAN_SIZE_MAX - size);
        end
        return PIXEL_W'(top) << pos;
    endfunction

endpackage

### rtl/line_pixel_rasterizer.sv
// channel | direction | handshake                  | payload
// in      | input     | i_in_valid / o_in_ready    | op, start/end coordinates, rgb
// out     | output    | o_out_valid / i_out_ready  | pixel_valid, offset, colour, flags
// cfg     | input     | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// one item per clock when not stalled; each item yields exactly one pixel result
// the walker step registers into a pixel stage, then the row multiply
// (y * pitch) and clip register into the output stage
// a stalled output holds the pipeline; input is still taken while the pixel
// stage is empty, so an item enters while a finished result waits
// reset (synchronous, active low) clears the walker, pipeline and registers
module line_pixel_rasterizer #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_op,
    input  logic signed [15:0]            i_start_x,
    input  logic signed [15:0]            i_start_y,
    input  logic signed [15:0]            i_end_x_in,
    input  logic signed [15:0]            i_end_y_in,
    input  logic [7:0]                    i_red,
    input  logic [7:0]                    i_green,
    input  logic [7:0]                    i_blue,

    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_pixel_valid,
    output logic [31:0]                   o_byte_offset,
    output logic [31:0]                   o_pixel_color,
    output logic                          o_four_bytes,
    output logic                          o_line_done,

    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [lpr_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [lpr_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import lpr_pkg::*;

    localparam int CW = COORD_WIDTH;

    // configuration
    logic                r_enable;
    logic [FB_DIM_W-1:0] r_fb_width;
    logic [FB_DIM_W-1:0] r_fb_height;
    logic [PITCH_W-1:0]  r_row_pitch;
    logic [BPP_W-1:0]    r_bpp;
    logic [LAYOUT_W-1:0] r_red_layout;
    logic [LAYOUT_W-1:0] r_green_layout;
    logic [LAYOUT_W-1:0] r_blue_layout;

    // walker state
    logic signed [CW-1:0] r_cur_x, r_cur_y, r_tgt_x, r_tgt_y;
    logic signed [CW-1:0] n_cur_x, n_cur_y, n_tgt_x, n_tgt_y;
    logic [CW:0]          r_adx, r_ady, n_adx, n_ady;
    logic                 r_step_neg_x, r_step_neg_y, n_step_neg_x, n_step_neg_y;
    logic signed [CW+1:0] r_err, n_err;
    logic [PIXEL_W-1:0]   r_color, n_color;
    logic                 r_line_active, n_line_active;

    // pixel stage
    logic                 r_s1_valid, n_s1_valid;
    logic signed [CW-1:0] r_s1_x, r_s1_y, n_s1_x, n_s1_y;
    logic                 r_s1_live, n_s1_live;
    logic                 r_s1_done, n_s1_done;
    logic [PIXEL_W-1:0]   r_s1_color, n_s1_color;

    // output stage
    logic                 r_out_valid;
    logic                 r_out_pixel_valid;
    logic [31:0]          r_out_offset;
    logic [31:0]          r_out_color;
    logic                 r_out_four;
    logic                 r_out_done;

    logic w_adv_out, w_in_fire;

    assign w_adv_out   = !r_out_valid || i_out_ready;
    assign o_in_ready  = !r_s1_valid || w_adv_out;
    assign w_in_fire   = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable       <= 1'b0;
            r_fb_width     <= '0;
            r_fb_height    <= '0;
            r_row_pitch    <= '0;
            r_bpp          <= BPP_4;
            r_red_layout   <= '0;
            r_green_layout <= '0;
            r_blue_layout  <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_ENABLE:          r_enable       <= i_cfg_data[0];
                CFG_FB_WIDTH:        r_fb_width     <= i_cfg_data[FB_DIM_W-1:0];
                CFG_FB_HEIGHT:       r_fb_height    <= i_cfg_data[FB_DIM_W-1:0];
                CFG_ROW_PITCH:       r_row_pitch    <= i_cfg_data[PITCH_W-1:0];
                CFG_BYTES_PER_PIXEL: r_bpp          <= i_cfg_data[BPP_W-1:0];
                CFG_RED_LAYOUT:      r_red_layout   <= i_cfg_data[LAYOUT_W-1:0];
                CFG_GREEN_LAYOUT:    r_green_layout <= i_cfg_data[LAYOUT_W-1:0];
                CFG_BLUE_LAYOUT:     r_blue_layout  <= i_cfg_data[LAYOUT_W-1:0];
                default: ;
            endcase
        end
    end

    // start item setup
    logic signed [CW-1:0] w_x0, w_y0, w_x1, w_y1;
    logic signed [CW:0]   w_dx, w_dy;
    logic [CW:0]          w_adx, w_ady;
    logic signed [CW+1:0] w_err_start;
    logic [PIXEL_W-1:0]   w_color_start;

    assign w_x0 = i_start_x[CW-1:0];
    assign w_y0 = i_start_y[CW-1:0];
    assign w_x1 = i_end_x_in[CW-1:0];
    assign w_y1 = i_end_y_in[CW-1:0];
    assign w_dx = {w_x1[CW-1], w_x1} - {w_x0[CW-1], w_x0};
    assign w_dy = {w_y1[CW-1], w_y1} - {w_y0[CW-1], w_y0};
    assign w_adx = w_dx[CW] ? -w_dx : w_dx;
    assign w_ady = w_dy[CW] ? -w_dy : w_dy;
    assign w_err_start = (w_adx > w_ady) ? {2'b00, w_adx[CW:1]} : -{2'b00, w_ady[CW:1]};
    assign w_color_start = pack_channel(i_red, r_red_layout)
                         | pack_channel(i_green, r_green_layout)
                         | pack_channel(i_blue, r_blue_layout);

    // one bresenham step
    logic signed [CW+1:0] w_adx_s, w_ady_s, w_err_step;
    logic                 w_step_x, w_step_y;
    logic signed [CW-1:0] w_x_step, w_y_step;

    assign w_adx_s  = $signed({1'b0, r_adx});
    assign w_ady_s  = $signed({1'b0, r_ady});
    assign w_step_x = r_err > -w_adx_s;
    assign w_step_y = r_err < w_ady_s;
    assign w_err_step = r_err - (w_step_x ? w_ady_s : '0) + (w_step_y ? w_adx_s : '0);
    assign w_x_step = !w_step_x ? r_cur_x :
                      (r_step_neg_x ? r_cur_x - CW'(1) : r_cur_x + CW'(1));
    assign w_y_step = !w_step_y ? r_cur_y :
                      (r_step_neg_y ? r_cur_y - CW'(1) : r_cur_y + CW'(1));

    always_comb begin
        n_cur_x       = r_cur_x;
        n_cur_y       = r_cur_y;
        n_tgt_x       = r_tgt_x;
        n_tgt_y       = r_tgt_y;
        n_adx         = r_adx;
        n_ady         = r_ady;
        n_step_neg_x  = r_step_neg_x;
        n_step_neg_y  = r_step_neg_y;
        n_err         = r_err;
        n_color       = r_color;
        n_line_active = r_line_active;
        n_s1_valid    = r_s1_valid && !w_adv_out;
        n_s1_x        = r_s1_x;
        n_s1_y        = r_s1_y;
        n_s1_live     = r_s1_live;
        n_s1_done     = r_s1_done;
        n_s1_color    = r_s1_color;
        if (w_in_fire) begin
            n_s1_valid = 1'b1;
            if (t_op'(i_op) == OP_START) begin
                n_cur_x       = w_x0;
                n_cur_y       = w_y0;
                n_tgt_x       = w_x1;
                n_tgt_y       = w_y1;
                n_adx         = w_adx;
                n_ady         = w_ady;
                n_step_neg_x  = w_dx[CW];
                n_step_neg_y  = w_dy[CW];
                n_err         = w_err_start;
                n_color       = w_color_start;
                n_line_active = (w_x0 != w_x1) || (w_y0 != w_y1);
                n_s1_x        = w_x0;
                n_s1_y        = w_y0;
                n_s1_live     = 1'b1;
                n_s1_done     = !n_line_active;
                n_s1_color    = w_color_start;
            end else if (r_line_active) begin
                n_cur_x       = w_x_step;
                n_cur_y       = w_y_step;
                n_err         = w_err_step;
                n_line_active = (w_x_step != r_tgt_x) || (w_y_step != r_tgt_y);
                n_s1_x        = w_x_step;
                n_s1_y        = w_y_step;
                n_s1_live     = 1'b1;
                n_s1_done     = !n_line_active;
                n_s1_color    = r_color;
            end else begin
                // advance with no line: empty pixel marked done
                n_s1_live = 1'b0;
                n_s1_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x       <= '0;
            r_cur_y       <= '0;
            r_tgt_x       <= '0;
            r_tgt_y       <= '0;
            r_adx         <= '0;
            r_ady         <= '0;
            r_step_neg_x  <= 1'b0;
            r_step_neg_y  <= 1'b0;
            r_err         <= '0;
            r_color       <= '0;
            r_line_active <= 1'b0;
            r_s1_valid    <= 1'b0;
        end else begin
            r_cur_x       <= n_cur_x;
            r_cur_y       <= n_cur_y;
            r_tgt_x       <= n_tgt_x;
            r_tgt_y       <= n_tgt_y;
            r_adx         <= n_adx;
            r_ady         <= n_ady;
            r_step_neg_x  <= n_step_neg_x;
            r_step_neg_y  <= n_step_neg_y;
            r_err         <= n_err;
            r_color       <= n_color;
            r_line_active <= n_line_active;
            r_s1_valid    <= n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_x     <= n_s1_x;
        r_s1_y     <= n_s1_y;
        r_s1_live  <= n_s1_live;
        r_s1_done  <= n_s1_done;
        r_s1_color <= n_s1_color;
    end

    // clip and address
    logic [CW-2:0]  w_x_u, w_y_u;
    logic           w_bpp_ok, w_bpp4, w_ok;
    logic [CW+14:0] w_row_off;
    logic [CW:0]    w_col_off;
    logic [31:0]    w_offset;

    assign w_x_u    = r_s1_x[CW-2:0];
    assign w_y_u    = r_s1_y[CW-2:0];
    assign w_bpp4   = r_bpp == BPP_4;
    assign w_bpp_ok = (r_bpp == BPP_3) || w_bpp4;
    assign w_ok = r_s1_live && r_enable && w_bpp_ok && !r_s1_x[CW-1] && !r_s1_y[CW-1]
               && (32'(w_x_u) < 32'(r_fb_width)) && (32'(w_y_u) < 32'(r_fb_height));
    assign w_row_off = w_y_u * r_row_pitch;
    assign w_col_off = w_bpp4 ? {w_x_u, 2'b00} : ({2'b00, w_x_u} + {1'b0, w_x_u, 1'b0});
    assign w_offset  = 32'(w_row_off) + 32'(w_col_off);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv_out) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv_out) begin
            r_out_pixel_valid <= w_ok;
            r_out_offset      <= w_ok ? w_offset : '0;
            r_out_color       <= w_ok ? r_s1_color : '0;
            r_out_four        <= w_ok && w_bpp4;
            r_out_done        <= r_s1_done;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pixel_valid = r_out_pixel_valid;
    assign o_byte_offset = r_out_offset;
    assign o_pixel_color = r_out_color;
    assign o_four_bytes  = r_out_four;
    assign o_line_done   = r_out_done;

    // an active line never sits on its endpoint
    a_active_not_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line_active |-> (r_cur_x != r_tgt_x) || (r_cur_y != r_tgt_y))
        else $error("line active at its endpoint");

    // a held pixel stage is kept while the output is stalled
    a_s1_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !w_adv_out |=> r_s1_valid && $stable(r_s1_x) && $stable(r_s1_y))
        else $error("pixel stage lost while stalled");

    // an advance with no line leaves the walker alone
    a_idle_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_fire && i_op && !r_line_active |=> !r_line_active && $stable(r_cur_x)
        && $stable(r_cur_y))
        else $error("idle advance moved the walker");

endmodule
